FILE: rtl/core/h264kf_pkg.sv
package h264kf_pkg;

  // Width of the STAP unit length counter
  localparam int LENGTH_BITS = 16;
  localparam longint unsigned CNT_MAX = (64'd1 << LENGTH_BITS) - 64'd1;

  localparam logic [4:0] NAL_SLICE  = 5'd1;
  localparam logic [4:0] NAL_PART_A = 5'd2;
  localparam logic [4:0] NAL_IDR    = 5'd5;
  localparam logic [4:0] NAL_SPS    = 5'd7;
  localparam logic [4:0] NAL_PPS    = 5'd8;
  localparam logic [4:0] NAL_STAP_A = 5'd24;
  localparam logic [4:0] NAL_STAP_B = 5'd25;
  localparam logic [4:0] NAL_FU_A   = 5'd28;

  localparam logic [7:0] PROFILE_BASELINE = 8'd66;
  localparam logic [7:0] PROFILE_MAIN     = 8'd77;
  localparam logic [7:0] PROFILE_EXTENDED = 8'd88;
  localparam logic [7:0] PROFILE_HIGH     = 8'd100;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_INTER = 2'd1,
    KIND_INTRA = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    UPD_NONE  = 2'd0,
    UPD_SET   = 2'd1,
    UPD_CLEAR = 2'd2
  } upd_t;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_SINGLE    = 4'd1,
    PH_WAIT      = 4'd2,
    PH_FU_HDR    = 4'd3,
    PH_FU_KEY    = 4'd4,
    PH_DON_A     = 4'd5,
    PH_DON_B     = 4'd6,
    PH_LEN_HI    = 4'd7,
    PH_LEN_LO    = 4'd8,
    PH_UNIT_HDR  = 4'd9,
    PH_UNIT_KEY  = 4'd10,
    PH_UNIT_BODY = 4'd11,
    PH_SKIP      = 4'd12
  } phase_t;

  typedef struct packed {
    kind_t kind;
    upd_t  sps_upd;
    logic  pps_upd;
  } pending_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } step_t;

  // Classify a plain NAL unit from its type and second byte
  function automatic pending_t classify(logic [4:0] nal, logic [7:0] key,
                                        logic sps, logic pps);
    pending_t p;
    p = '0;
    case (nal) inside
      NAL_SLICE, NAL_PART_A: begin
        if (key[7]) p.kind = KIND_INTER;
      end
      NAL_IDR: begin
        if (sps && pps && key[7]) p.kind = KIND_INTRA;
      end
      NAL_SPS: begin
        p.sps_upd = (key == PROFILE_BASELINE || key == PROFILE_MAIN ||
                     key == PROFILE_EXTENDED || key == PROFILE_HIGH) ? UPD_SET : UPD_CLEAR;
      end
      NAL_PPS: begin
        p.pps_upd = 1'b1;
      end
      default: begin
      end
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/core/h264kf_if.sv
interface h264kf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface h264kf_kind_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_kind;

  modport source (output valid, output frame_kind, input ready);
  modport sink (input valid, input frame_kind, output ready);
endinterface

FILE: rtl/core/h264kf_parse.sv
module h264kf_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  h264kf_pkg::step_t   item,
  output h264kf_pkg::kind_t   kind
);
  import h264kf_pkg::*;

  phase_t                 phase, phase_next;
  logic                   sps_seen, sps_seen_next;
  logic                   pps_seen, pps_seen_next;
  logic [LENGTH_BITS-1:0] unit_remaining, unit_remaining_next;
  logic [7:0]             length_high_byte, length_high_byte_next;
  logic [4:0]             unit_nal_type, unit_nal_type_next;
  pending_t               pending, pending_next;
  kind_t                  decided_kind, decided_kind_next;
  logic                   decided_flag, decided_flag_next;

  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   rem_done;
  logic [15:0]            unit_len;
  logic                   len_over;
  logic [4:0]             hdr_type;
  logic                   commit_decides;

  assign rem_dec        = unit_remaining - LENGTH_BITS'(1);
  assign rem_done       = (rem_dec == '0);
  assign unit_len       = {length_high_byte, item.byte_value};
  assign len_over       = (64'(unit_len) > CNT_MAX);
  assign hdr_type       = item.byte_value[4:0];
  assign commit_decides = decided_flag || (pending.kind != KIND_NONE);

  // Next parse phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEADER: begin
        case (hdr_type) inside
          NAL_STAP_A: phase_next = PH_LEN_HI;
          NAL_STAP_B: phase_next = PH_DON_A;
          NAL_FU_A:   phase_next = PH_FU_HDR;
          NAL_SLICE, NAL_PART_A, NAL_IDR, NAL_SPS, NAL_PPS: phase_next = PH_SINGLE;
          default:    phase_next = PH_SKIP;
        endcase
      end
      PH_SINGLE:   phase_next = PH_WAIT;
      PH_FU_HDR:   phase_next = item.byte_value[7] ? PH_FU_KEY : PH_SKIP;
      PH_FU_KEY:   phase_next = PH_WAIT;
      PH_DON_A:    phase_next = PH_DON_B;
      PH_DON_B:    phase_next = PH_LEN_HI;
      PH_LEN_HI:   phase_next = PH_LEN_LO;
      PH_LEN_LO: begin
        if (len_over) phase_next = PH_SKIP;
        else if (unit_len == 16'd0) phase_next = PH_LEN_HI;
        else phase_next = PH_UNIT_HDR;
      end
      PH_UNIT_HDR: phase_next = rem_done ? PH_LEN_HI : PH_UNIT_KEY;
      PH_UNIT_KEY: phase_next = rem_done ? PH_LEN_HI : PH_UNIT_BODY;
      PH_UNIT_BODY: begin
        if (rem_done) phase_next = commit_decides ? PH_SKIP : PH_LEN_HI;
      end
      default: phase_next = phase;
    endcase
    if (item.last_byte) phase_next = PH_HEADER;
  end

  // Datapath updates
  always_comb begin
    logic do_commit;
    do_commit              = 1'b0;
    sps_seen_next          = sps_seen;
    pps_seen_next          = pps_seen;
    unit_remaining_next    = unit_remaining;
    length_high_byte_next  = length_high_byte;
    unit_nal_type_next     = unit_nal_type;
    pending_next           = pending;
    decided_kind_next      = decided_kind;
    decided_flag_next      = decided_flag;
    unique case (phase)
      PH_HEADER: unit_nal_type_next = hdr_type;
      PH_SINGLE, PH_FU_KEY: begin
        pending_next = classify(unit_nal_type, item.byte_value, sps_seen, pps_seen);
      end
      PH_FU_HDR: begin
        if (item.byte_value[7]) unit_nal_type_next = hdr_type;
      end
      PH_LEN_HI: length_high_byte_next = item.byte_value;
      PH_LEN_LO: begin
        if (!len_over && unit_len != 16'd0) unit_remaining_next = LENGTH_BITS'(unit_len);
      end
      PH_UNIT_HDR: begin
        unit_nal_type_next  = hdr_type;
        pending_next        = '0;
        unit_remaining_next = rem_dec;
      end
      PH_UNIT_KEY: begin
        unit_remaining_next = rem_dec;
        // nested aggregation or fragments inside a unit give nothing
        if (rem_done || unit_nal_type == NAL_STAP_A || unit_nal_type == NAL_STAP_B ||
            unit_nal_type == NAL_FU_A) begin
          pending_next = '0;
        end else begin
          pending_next = classify(unit_nal_type, item.byte_value, sps_seen, pps_seen);
        end
      end
      PH_UNIT_BODY: begin
        unit_remaining_next = rem_dec;
        do_commit = rem_done;
      end
      PH_WAIT: do_commit = item.last_byte;
      default: begin
      end
    endcase

    if (do_commit) begin
      if (pending.sps_upd == UPD_SET) sps_seen_next = 1'b1;
      else if (pending.sps_upd == UPD_CLEAR) sps_seen_next = 1'b0;
      if (pending.pps_upd) pps_seen_next = 1'b1;
      if (pending.kind != KIND_NONE) begin
        decided_kind_next = pending.kind;
        decided_flag_next = 1'b1;
      end
      pending_next = '0;
    end

    kind = decided_flag_next ? decided_kind_next : KIND_NONE;

    // end of packet: drop all per-packet state
    if (item.last_byte) begin
      unit_remaining_next   = '0;
      length_high_byte_next = '0;
      unit_nal_type_next    = '0;
      pending_next          = '0;
      decided_kind_next     = KIND_NONE;
      decided_flag_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      sps_seen         <= 1'b0;
      pps_seen         <= 1'b0;
      unit_remaining   <= '0;
      length_high_byte <= '0;
      unit_nal_type    <= '0;
      pending          <= '0;
      decided_kind     <= KIND_NONE;
      decided_flag     <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      sps_seen         <= sps_seen_next;
      pps_seen         <= pps_seen_next;
      unit_remaining   <= unit_remaining_next;
      length_high_byte <= length_high_byte_next;
      unit_nal_type    <= unit_nal_type_next;
      pending          <= pending_next;
      decided_kind     <= decided_kind_next;
      decided_flag     <= decided_flag_next;
    end
  end

endmodule

FILE: rtl/core/h264_rtp_key_frame_detector.sv
// Channel   Role    Payload                  Item
// payload   sink    byte_value, last_byte    one RTP payload byte
// result    source  frame_kind               one per packet, after its last byte
//
// One byte per cycle while no last byte waits: a byte enters the input register,
// the parser updates its state from it, and the packet result goes to the output register.
// rst clears the parse state, the SPS/PPS flags and both valid bits.
// A pending result holds only a last byte in the input register; other bytes keep flowing.
module h264_rtp_key_frame_detector (
  input logic          clk,
  input logic          rst,
  h264kf_byte_if.sink  payload,
  h264kf_kind_if.source result
);
  import h264kf_pkg::*;

  logic  in_valid;
  step_t in_item;
  logic  out_valid;
  kind_t out_kind;
  kind_t parse_kind;
  logic  out_free;
  logic  fire;

  assign out_free      = !out_valid || result.ready;
  assign fire          = in_valid && (!in_item.last_byte || out_free);
  assign payload.ready = !in_valid || fire;

  assign result.valid      = out_valid;
  assign result.frame_kind = out_kind;

  h264kf_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (fire),
    .item (in_item),
    .kind (parse_kind)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (payload.ready) begin
      in_valid <= payload.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (payload.valid && payload.ready) begin
      in_item.byte_value <= payload.byte_value;
      in_item.last_byte  <= payload.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // load the packet result with the last byte
  always_ff @(posedge clk) begin
    if (fire && in_item.last_byte) begin
      out_kind <= parse_kind;
    end
  end

endmodule

FILE: verif/h264_rtp_key_frame_detector_tb.sv
module h264_rtp_key_frame_detector_tb;
  import h264kf_pkg::*;

  localparam int BYTE_TARGET = 1450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_WAIT    = 11;

  // {last_byte, byte_value}
  localparam logic [8:0] DIRECTED_BYTES [27] = '{
    9'h1ff,
    9'h100,
    9'h065, 9'h080, 9'h100,
    9'h067, 9'h042, 9'h100,
    9'h068, 9'h0ce, 9'h100,
    9'h065, 9'h088, 9'h100,
    9'h041, 9'h19a,
    9'h07c, 9'h085, 9'h088, 9'h100,
    9'h018, 9'h000, 9'h003, 9'h041, 9'h080, 9'h000, 9'h100
  };

  class frame_kind_scoreboard;
    bit                     have_sps;
    bit                     have_pps;
    phase_t                 phase;
    logic [LENGTH_BITS-1:0] remain;
    logic [7:0]             len_hi;
    logic [4:0]             nal;
    kind_t                  pend_kind;
    upd_t                   pend_sps;
    bit                     pend_pps;
    kind_t                  chosen;
    bit                     chosen_ok;
    kind_t                  expected_kinds[$];
    int                     errors;
    int                     results_seen;

    function new();
      have_sps = 1'b0;
      have_pps = 1'b0;
      errors = 0;
      results_seen = 0;
      restart_packet();
    endfunction

    function void drop_pending();
      pend_kind = KIND_NONE;
      pend_sps = UPD_NONE;
      pend_pps = 1'b0;
    endfunction

    function void restart_packet();
      phase = PH_HEADER;
      remain = '0;
      len_hi = '0;
      nal = '0;
      drop_pending();
      chosen = KIND_NONE;
      chosen_ok = 1'b0;
    endfunction

    function void grade(logic [4:0] t, logic [7:0] key);
      drop_pending();
      if (t == NAL_SLICE || t == NAL_PART_A) begin
        if (key[7]) pend_kind = KIND_INTER;
      end else if (t == NAL_IDR) begin
        if (have_sps && have_pps && key[7]) pend_kind = KIND_INTRA;
      end else if (t == NAL_SPS) begin
        pend_sps = (key == PROFILE_BASELINE || key == PROFILE_MAIN ||
                    key == PROFILE_EXTENDED || key == PROFILE_HIGH) ? UPD_SET : UPD_CLEAR;
      end else if (t == NAL_PPS) begin
        pend_pps = 1'b1;
      end
    endfunction

    // Apply the finished unit's updates and decision
    function void settle();
      if (pend_sps == UPD_SET) have_sps = 1'b1;
      else if (pend_sps == UPD_CLEAR) have_sps = 1'b0;
      if (pend_pps) have_pps = 1'b1;
      if (pend_kind != KIND_NONE) begin
        chosen = pend_kind;
        chosen_ok = 1'b1;
      end
      drop_pending();
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [15:0] unit_len;
      case (phase)
        PH_HEADER: begin
          nal = b[4:0];
          case (b[4:0])
            NAL_STAP_A: phase = PH_LEN_HI;
            NAL_STAP_B: phase = PH_DON_A;
            NAL_FU_A:   phase = PH_FU_HDR;
            NAL_SLICE, NAL_PART_A, NAL_IDR, NAL_SPS, NAL_PPS: phase = PH_SINGLE;
            default:    phase = PH_SKIP;
          endcase
        end
        PH_SINGLE, PH_FU_KEY: begin
          grade(nal, b);
          phase = PH_WAIT;
        end
        PH_FU_HDR: begin
          if (b[7]) begin
            nal = b[4:0];
            phase = PH_FU_KEY;
          end else begin
            phase = PH_SKIP;
          end
        end
        PH_DON_A: phase = PH_DON_B;
        PH_DON_B: phase = PH_LEN_HI;
        PH_LEN_HI: begin
          len_hi = b;
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          unit_len = {len_hi, b};
          if (64'(unit_len) > CNT_MAX) begin
            phase = PH_SKIP;
          end else if (unit_len == 16'd0) begin
            phase = PH_LEN_HI;
          end else begin
            remain = LENGTH_BITS'(unit_len);
            phase = PH_UNIT_HDR;
          end
        end
        PH_UNIT_HDR: begin
          nal = b[4:0];
          drop_pending();
          remain = remain - 1'b1;
          phase = (remain == 0) ? PH_LEN_HI : PH_UNIT_KEY;
        end
        PH_UNIT_KEY: begin
          // nested aggregation or fragments never decide anything
          if (nal == NAL_STAP_A || nal == NAL_STAP_B || nal == NAL_FU_A) drop_pending();
          else grade(nal, b);
          remain = remain - 1'b1;
          if (remain == 0) begin
            drop_pending();
            phase = PH_LEN_HI;
          end else begin
            phase = PH_UNIT_BODY;
          end
        end
        PH_UNIT_BODY: begin
          remain = remain - 1'b1;
          if (remain == 0) begin
            settle();
            phase = chosen_ok ? PH_SKIP : PH_LEN_HI;
          end
        end
        PH_WAIT: begin
          if (last) settle();
        end
        default: begin
        end
      endcase
      if (last) begin
        expected_kinds.push_back(chosen_ok ? chosen : KIND_NONE);
        restart_packet();
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_kind(logic [1:0] got);
      kind_t want;
      if (expected_kinds.size() == 0) begin
        report_mismatch($sformatf("frame_kind %0d with no packet waiting", got));
      end else begin
        want = expected_kinds.pop_front();
        if (got !== want)
          report_mismatch($sformatf("packet %0d: frame_kind %0d, expected %0d",
                                    results_seen, got, want));
      end
      results_seen++;
    endtask

    task finish();
      if (expected_kinds.size() != 0)
        report_mismatch($sformatf("%0d packet results never arrived", expected_kinds.size()));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   calm;
  int   cycles;
  int   bytes_sent;
  int   packet_no;
  logic [7:0] pkt[$];

  frame_kind_scoreboard sb = new();

  h264kf_byte_if payload_if();
  h264kf_kind_if result_if();

  h264_rtp_key_frame_detector uut (
    .clk(clk),
    .rst(rst),
    .payload(payload_if),
    .result(result_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("h264_rtp_key_frame_detector_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_if.valid && result_if.ready) sb.check_kind(result_if.frame_kind);
      if (payload_if.valid && payload_if.ready)
        sb.note_byte(payload_if.byte_value, payload_if.last_byte);
    end
  end

  // Result side: stall a random count before each item, hold ready until taken
  initial begin
    int stall;
    result_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!(result_if.valid && result_if.ready));
      @(negedge clk);
    end
  end

  // Called and returns at a falling edge
  task send_byte(logic [7:0] b, logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      payload_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    payload_if.valid <= 1'b1;
    payload_if.byte_value <= b;
    payload_if.last_byte <= last;
    do @(posedge clk); while (!payload_if.ready);
    @(negedge clk);
  endtask

  task send_packet();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    bytes_sent += pkt.size();
    packet_no++;
  endtask

  // Hold the sender until every packet result is back
  task drain_results();
    payload_if.valid <= 1'b0;
    do @(negedge clk); while (sb.expected_kinds.size() != 0);
  endtask

  function automatic logic [7:0] nal_byte(logic [4:0] t);
    logic [2:0] top;
    top = 3'($urandom_range(0, 7));
    return {top, t};
  endfunction

  function automatic logic [7:0] pick_profile();
    case ($urandom_range(0, 3))
      0: return PROFILE_BASELINE;
      1: return PROFILE_MAIN;
      2: return PROFILE_EXTENDED;
      default: return PROFILE_HIGH;
    endcase
  endfunction

  function automatic logic [4:0] pick_type(bit nested_ok);
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return NAL_SLICE;
    if (r < 32) return NAL_PART_A;
    if (r < 52) return NAL_IDR;
    if (r < 67) return NAL_SPS;
    if (r < 80) return NAL_PPS;
    if (r < 90 && nested_ok) begin
      case ($urandom_range(0, 2))
        0: return NAL_STAP_A;
        1: return NAL_STAP_B;
        default: return NAL_FU_A;
      endcase
    end
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [7:0] pick_key(logic [4:0] t);
    if (t == NAL_SPS && $urandom_range(0, 3) != 0) return pick_profile();
    if ($urandom_range(0, 3) != 0) return {1'b1, 7'($urandom)};
    return 8'($urandom);
  endfunction

  function automatic void add_body(int n);
    repeat (n) pkt.push_back(8'($urandom));
  endfunction

  function automatic void build_single(logic [4:0] t, logic [7:0] key);
    pkt.delete();
    pkt.push_back(nal_byte(t));
    pkt.push_back(key);
    add_body($urandom_range(0, 3));
  endfunction

  function automatic void build_fu();
    logic [4:0] t;
    logic       start;
    t = pick_type(1'b1);
    start = ($urandom_range(0, 4) != 0);
    pkt.delete();
    pkt.push_back(nal_byte(NAL_FU_A));
    pkt.push_back({start, 2'($urandom), t});
    pkt.push_back(pick_key(t));
    add_body($urandom_range(0, 4));
  endfunction

  // Length prefix, then c_len bytes of unit content
  function automatic void add_unit(int c_len, int declared);
    logic [4:0] t;
    t = pick_type(1'b1);
    pkt.push_back(8'(declared >> 8));
    pkt.push_back(8'(declared));
    if (c_len >= 1) pkt.push_back(nal_byte(t));
    if (c_len >= 2) pkt.push_back(pick_key(t));
    if (c_len > 2) add_body(c_len - 2);
  endfunction

  function automatic void build_stap(bit with_don);
    int r;
    int c_len;
    pkt.delete();
    pkt.push_back(nal_byte(with_don ? NAL_STAP_B : NAL_STAP_A));
    if (with_don) add_body(2);
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(0, 19);
      c_len = (r == 0) ? 0 : (r < 3) ? 1 : (r < 5) ? 2 : 2 + $urandom_range(1, 4);
      add_unit(c_len, c_len);
    end
    case ($urandom_range(0, 9))
      0: pkt.push_back(8'($urandom));
      1: begin
        c_len = $urandom_range(1, 5);
        add_unit(c_len, c_len + $urandom_range(1, 3));
      end
      2: begin
        pkt.push_back(8'hff);
        pkt.push_back(8'hff);
        add_body($urandom_range(0, 4));
      end
      default: begin
      end
    endcase
  endfunction

  initial begin
    int r;
    int keep;
    rst = 1'b1;
    calm = 1'b0;
    cycles = 0;
    bytes_sent = 0;
    packet_no = 0;
    payload_if.valid = 1'b0;
    payload_if.byte_value = '0;
    payload_if.last_byte = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
    drain_results();

    while (bytes_sent < BYTE_TARGET) begin
      if (packet_no % 30 == 0) calm = ($urandom_range(0, 2) == 0);
      if (packet_no == 90) drain_results();
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // parameter sets followed by a key frame slice
        build_single(NAL_SPS, pick_profile());
        send_packet();
        build_single(NAL_PPS, 8'($urandom));
        send_packet();
        build_single(NAL_IDR, {1'b1, 7'($urandom)});
        send_packet();
      end else begin
        if (r < 40) begin
          build_single(pick_type(1'b0), 8'h00);
          pkt[1] = pick_key(pkt[0][4:0]);
        end else if (r < 58) begin
          build_fu();
        end else if (r < 73) begin
          build_stap(1'b0);
        end else if (r < 85) begin
          build_stap(1'b1);
        end else begin
          pkt.delete();
          add_body($urandom_range(1, 8));
        end
        if ($urandom_range(0, 9) == 0) begin
          keep = $urandom_range(1, pkt.size());
          while (pkt.size() > keep) void'(pkt.pop_back());
        end
        send_packet();
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    sb.finish();
    if (sb.errors == 0) begin
      $display("h264_rtp_key_frame_detector_tb: clean");
    end else begin
      $display("h264_rtp_key_frame_detector_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/h264kf_pkg.sv
rtl/core/h264kf_if.sv
rtl/core/h264kf_parse.sv
rtl/core/h264_rtp_key_frame_detector.sv
verif/h264_rtp_key_frame_detector_tb.sv
